// ===== sv/mme_pkg.sv =====
`default_nettype none

package mme_pkg;

  // fixed field widths of the item, result and configuration words
  localparam int OP_W      = 2;
  localparam int IDX_W     = 6;
  localparam int ELEM_W    = 16;
  localparam int VALUE_W   = 38;
  localparam int COL_W     = 6;
  localparam int DIM_REG_W = 7;
  localparam int CFG_IDX_W = 2;

  // opcodes
  localparam logic [OP_W-1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] product_value;
    logic [COL_W-1:0]          product_column;
    logic                      last_of_row;
    logic                      index_error;
  } out_word_t;

  // tag that travels along the cell chain with each term
  typedef struct packed {
    logic v;
    logic first;
    logic last;
  } tag_t;

  // result chain control
  typedef struct packed {
    logic cap;
    logic shift;
  } drain_t;

endpackage

`default_nettype wire

// ===== sv/mme_cell.sv =====
`default_nettype none

module mme_cell #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [ELEM_WIDTH-1:0]          a_in,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] t_in,
  input  mme_pkg::tag_t                         tag_in,
  output logic signed [ELEM_WIDTH-1:0]          a_out,
  output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] t_out,
  output mme_pkg::tag_t                         tag_out,
  input  logic                                  we,
  input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] waddr,
  input  logic signed [ELEM_WIDTH-1:0]          wdata,
  input  mme_pkg::drain_t                       drain,
  input  logic signed [mme_pkg::VALUE_W-1:0]    res_in,
  output logic signed [mme_pkg::VALUE_W-1:0]    res_out,
  output logic                                  done
);
  import mme_pkg::*;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = 1 << DIM_W;
  localparam int PROD_W = 2 * ELEM_WIDTH;

  // one column of the right matrix, addressed by inner index
  logic signed [ELEM_WIDTH-1:0] col_mem [DEPTH];

  logic signed [ELEM_WIDTH-1:0] a_r;
  logic signed [ELEM_WIDTH-1:0] b_q_r;
  logic [DIM_W-1:0]             t_r;
  tag_t                         tag_r;
  tag_t                         tag2_r;
  logic signed [PROD_W-1:0]     prod_r;
  logic signed [VALUE_W-1:0]    acc_r;
  logic signed [VALUE_W-1:0]    acc_nxt;
  logic signed [VALUE_W-1:0]    res_r;
  logic signed [VALUE_W-1:0]    res_nxt;
  logic                         done_r;

  always_ff @(posedge clk) begin
    if (we) begin
      col_mem[waddr] <= wdata;
    end
    b_q_r <= col_mem[t_in];
  end

  always_comb begin
    acc_nxt = acc_r;
    if (tag2_r.v) begin
      if (tag2_r.first) begin
        acc_nxt = VALUE_W'(prod_r);
      end else begin
        acc_nxt = acc_r + VALUE_W'(prod_r);
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (drain.cap) begin
      res_nxt = acc_r;
    end else if (drain.shift) begin
      res_nxt = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;
      tag2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tag_r  <= tag_in;
      tag2_r <= tag_r;
      done_r <= tag2_r.v && tag2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_in;
    t_r    <= t_in;
    prod_r <= a_r * b_q_r;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign a_out   = a_r;
  assign t_out   = t_r;
  assign tag_out = tag_r;
  assign res_out = res_r;
  assign done    = done_r;

endmodule

`default_nettype wire

// ===== sv/matrix_multiply_engine.sv =====
`default_nettype none

// matrix multiply engine: rows of C = A x B over signed Q4.12 elements with
// exact Q14.24 sums (wrapping at 38 bits). words are taken one at a time.
// a load word (left or right element) leaves the block idle; a load whose index lies
// outside the configured sizes is dropped, and an unused opcode is dropped too.
// a compute word for row i streams A[i][0..inner_k-1] out of the left store
// into a chain of MAX_DIM identical cells, one per product column. each cell
// keeps its own column of B, multiplies the term passing by and accumulates,
// then hands the term to its neighbour on the next cycle. the first result is
// ready once the feed of inner_k terms has walked down the whole chain, and
// the cols_n results then leave one per cycle in column order while out_ready
// is high; last_of_row marks the final one. a compute row at or above rows_m
// gives a single word with index_error and last_of_row set and value zero.
// in_ready is high only while nothing is in flight. configuration writes
// (rows_m, inner_k, cols_n at indexes 0, 1, 2) are always ready and are to be
// issued only while the block is idle; 0 is taken as 1 and values above
// min(MAX_DIM, 64) as that bound. a store entry must be written before it is
// read; the stores are not cleared at reset.

module matrix_multiply_engine #(
  parameter int MAX_DIM    = 64,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  mme_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output mme_pkg::out_word_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::DIM_REG_W-1:0]     cfg_data
);
  import mme_pkg::*;

  localparam int DIM_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CMP_W      = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam int DIM_CAP    = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int LEFT_DEPTH = 1 << (2 * DIM_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FEED,
    S_WAIT,
    S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [DIM_W-1:0]         row_r, row_nxt;
  logic [DIM_W-1:0]         t_cnt_r, t_cnt_nxt;
  logic [COL_W-1:0]         col_cnt_r, col_cnt_nxt;
  logic                     err_r, err_nxt;
  logic [DIM_REG_W-1:0]     rows_m_r, inner_k_r, cols_n_r;

  // feed stage in front of the chain
  tag_t                         feed_tag_r, feed_tag_nxt;
  logic [DIM_W-1:0]             feed_t_r;
  logic signed [ELEM_WIDTH-1:0] left_q_r;

  // left matrix, addressed as {row, column}
  logic signed [ELEM_WIDTH-1:0] left_mem [LEFT_DEPTH];

  logic                         in_acc;
  logic                         row_in_range;
  logic                         left_we;
  logic                         right_ok;
  logic signed [ELEM_WIDTH-1:0] elem_val;
  logic [2*DIM_W-1:0]           left_waddr;
  logic [2*DIM_W-1:0]           left_raddr;
  logic                         t_last;
  logic                         col_last;
  drain_t                       drain;

  // chain wiring: entry j feeds cell j, entry j+1 is its output; results run from j+1 to j
  logic signed [ELEM_WIDTH-1:0] a_chain   [MAX_DIM+1];
  logic [DIM_W-1:0]             t_chain   [MAX_DIM+1];
  tag_t                         tag_chain [MAX_DIM+1];
  logic signed [VALUE_W-1:0]    res_chain [MAX_DIM+1];
  logic [MAX_DIM-1:0]           right_we;
  logic [MAX_DIM-1:0]           cell_done;

  function automatic logic [DIM_REG_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
    logic [DIM_REG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_REG_W'(1);
    end else if (CMP_W'(v) > CMP_W'(DIM_CAP)) begin
      r = DIM_REG_W'(DIM_CAP);
    end
    return r;
  endfunction

  // handshakes
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  // load decode; the stored pattern is the low element bits, zero extended
  assign row_in_range = DIM_REG_W'(in_data.row_index) < rows_m_r;
  assign elem_val     = ELEM_WIDTH'($unsigned(in_data.element_value));
  assign left_we      = in_acc && (in_data.opcode == OP_LOAD_LEFT) && row_in_range
                        && (DIM_REG_W'(in_data.col_index) < inner_k_r);
  assign right_ok     = in_acc && (in_data.opcode == OP_LOAD_RIGHT)
                        && (DIM_REG_W'(in_data.row_index) < inner_k_r)
                        && (DIM_REG_W'(in_data.col_index) < cols_n_r);
  assign left_waddr   = {DIM_W'(in_data.row_index), DIM_W'(in_data.col_index)};
  assign left_raddr   = {row_r, t_cnt_r};

  assign t_last   = CMP_W'(t_cnt_r) == CMP_W'(inner_k_r - DIM_REG_W'(1));
  assign col_last = DIM_REG_W'(col_cnt_r) == (cols_n_r - DIM_REG_W'(1));

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[left_waddr] <= elem_val;
    end
    left_q_r <= left_mem[left_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    t_cnt_nxt    = t_cnt_r;
    col_cnt_nxt  = col_cnt_r;
    err_nxt      = err_r;
    feed_tag_nxt = '0;
    drain        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.opcode == OP_COMPUTE)) begin
          col_cnt_nxt = '0;
          if (row_in_range) begin
            row_nxt   = DIM_W'(in_data.row_index);
            t_cnt_nxt = '0;
            err_nxt   = 1'b0;
            state_nxt = S_FEED;
          end else begin
            err_nxt   = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_FEED: begin
        feed_tag_nxt.v     = 1'b1;
        feed_tag_nxt.first = (t_cnt_r == '0);
        feed_tag_nxt.last  = t_last;
        t_cnt_nxt          = t_cnt_r + DIM_W'(1);
        if (t_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // the far end of the chain finishes last
        if (cell_done[MAX_DIM-1]) begin
          drain.cap   = 1'b1;
          col_cnt_nxt = '0;
          state_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (err_r || col_last) begin
            err_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            drain.shift = 1'b1;
            col_cnt_nxt = col_cnt_r + COL_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      err_r      <= 1'b0;
      col_cnt_r  <= '0;
      feed_tag_r <= '0;
    end else begin
      state_r    <= state_nxt;
      err_r      <= err_nxt;
      col_cnt_r  <= col_cnt_nxt;
      feed_tag_r <= feed_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    t_cnt_r  <= t_cnt_nxt;
    feed_t_r <= t_cnt_r;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_m_r  <= DIM_REG_W'(DIM_CAP);
      inner_k_r <= DIM_REG_W'(DIM_CAP);
      cols_n_r  <= DIM_REG_W'(DIM_CAP);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_M:  rows_m_r  <= clamp_dim(cfg_data);
        REG_INNER_K: inner_k_r <= clamp_dim(cfg_data);
        REG_COLS_N:  cols_n_r  <= clamp_dim(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // cell chain
  assign a_chain[0]         = left_q_r;
  assign t_chain[0]         = feed_t_r;
  assign tag_chain[0]       = feed_tag_r;
  assign res_chain[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    assign right_we[j] = right_ok && (CMP_W'(in_data.col_index) == CMP_W'(j));

    mme_cell #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .a_in    (a_chain[j]),
      .t_in    (t_chain[j]),
      .tag_in  (tag_chain[j]),
      .a_out   (a_chain[j+1]),
      .t_out   (t_chain[j+1]),
      .tag_out (tag_chain[j+1]),
      .we      (right_we[j]),
      .waddr   (DIM_W'(in_data.row_index)),
      .wdata   (elem_val),
      .drain   (drain),
      .res_in  (res_chain[j+1]),
      .res_out (res_chain[j]),
      .done    (cell_done[j])
    );
  end

  // result word: cell 0 holds the column being shown
  always_comb begin
    out_data.product_value  = err_r ? '0 : res_chain[0];
    out_data.product_column = col_cnt_r;
    out_data.last_of_row    = err_r || col_last;
    out_data.index_error    = err_r;
  end

endmodule

`default_nettype wire

// ===== sv/mme_checker.sv =====
`default_nettype none

module mme_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mme_pkg::out_word_t out_data
);
  import mme_pkg::*;

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no new word is taken while results are pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |->
      out_data.last_of_row && (out_data.product_value == '0)
      && (out_data.product_column == '0))
    else $error("malformed error word");

  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_of_row |=>
      out_valid && (out_data.product_column == $past(out_data.product_column) + COL_W'(1)))
    else $error("product column did not advance by one");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_of_row |=> !out_valid && in_ready)
    else $error("block not idle after last word of row");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire
